// File: src/free_list_block_allocator_assert.svh
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/fba_pkg.sv
package fba_pkg;

    localparam int DEFAULT_NUM_BLOCKS = 64;

    localparam int IN_INDEX_W  = 7;
    localparam int RES_INDEX_W = 6;
    localparam int STATUS_W    = 2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

    typedef struct packed {
        logic                  mode;
        logic [IN_INDEX_W-1:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [RES_INDEX_W-1:0] result_index;
    } t_out_item;

endpackage

// File: src/free_list_block_allocator.sv
// Result: registered when the execute state completes, which waits while the output
// is stalled. A new transaction is taken only in the idle state, after the block
// memory read and the write-back of the same entry for the previous one.
// Reset: head and fill mark clear; no memory clearing pass, entries at or above the
// fill mark read as never allocated.
`include "free_list_block_allocator_assert.svh"

module free_list_block_allocator #(
    parameter int NUM_BLOCKS = fba_pkg::DEFAULT_NUM_BLOCKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fba_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fba_pkg::t_out_item o_out_data
);

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int HW = $clog2(NUM_BLOCKS + 1);
    localparam int EW = (HW > fba_pkg::IN_INDEX_W) ? HW : fba_pkg::IN_INDEX_W;
    localparam int DW = HW + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state, n_state;
    logic [HW-1:0]      r_head, n_head;
    logic [HW-1:0]      r_fill, n_fill;
    logic               r_out_valid, n_out_valid;
    fba_pkg::t_out_item r_out, n_out;
    logic               r_mode;
    logic [EW-1:0]      r_idx;

    logic          in_accept;
    logic          out_taken;
    logic          exec_go;
    logic [EW-1:0] in_ext;
    logic [IW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          rd_busy;
    logic [HW-1:0] rd_link;
    logic          head_in, head_fresh, alloc_ok;
    logic [HW-1:0] link_eff;
    logic          idx_in, idx_fresh, free_ok;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_taken = r_out_valid && !i_out_stall;
    assign exec_go   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign in_ext    = EW'(i_in_data.block_index);
    assign rd_addr   = (i_in_data.mode == fba_pkg::MODE_FREE) ? in_ext[IW-1:0]
                                                              : r_head[IW-1:0];

    fba_ram #(
        .DEPTH(NUM_BLOCKS),
        .WIDTH(DW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_rd_en  (in_accept),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data)
    );

    assign rd_busy = rd_data[HW];
    assign rd_link = rd_data[HW-1:0];

    assign head_in    = r_head < HW'(NUM_BLOCKS);
    assign head_fresh = r_head >= r_fill;
    assign alloc_ok   = head_in && (head_fresh || !rd_busy);
    assign link_eff   = head_fresh ? (r_head + HW'(1)) : rd_link;

    assign idx_in    = r_idx < EW'(NUM_BLOCKS);
    assign idx_fresh = r_idx >= EW'(r_fill);
    assign free_ok   = idx_in && !idx_fresh && rd_busy;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out_valid = out_taken ? 1'b0 : r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_head[IW-1:0];
        wr_data     = {1'b1, link_eff};
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out.result_index = '0;
                    if (r_mode == fba_pkg::MODE_ALLOC) begin
                        if (alloc_ok) begin
                            wr_en  = 1'b1;
                            n_head = link_eff;
                            if (head_fresh) begin
                                n_fill = r_head + HW'(1);
                            end
                            n_out.status       = fba_pkg::STATUS_ALLOCATED;
                            n_out.result_index = fba_pkg::RES_INDEX_W'(r_head);
                        end else begin
                            n_out.status = fba_pkg::STATUS_EMPTY;
                        end
                    end else begin
                        wr_addr = r_idx[IW-1:0];
                        wr_data = {1'b0, r_head};
                        if (free_ok) begin
                            wr_en        = 1'b1;
                            n_head       = r_idx[HW-1:0];
                            n_out.status = fba_pkg::STATUS_FREED;
                        end else begin
                            n_out.status = fba_pkg::STATUS_IGNORED;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_accept) begin
            r_mode <= i_in_data.mode;
            r_idx  <= in_ext;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `FBA_ASSERT_NOW(a_fill_range, 1'b1, r_fill <= HW'(NUM_BLOCKS), "fill mark out of range")
    `FBA_ASSERT_NOW(a_head_range, 1'b1, r_head <= HW'(NUM_BLOCKS), "head out of range")
    `FBA_ASSERT_NEXT(a_accept_exec, in_accept, r_state == S_EXEC, "accepted item not executing")
    `FBA_ASSERT_NOW(a_index_zero,
        r_out_valid && (r_out.status != fba_pkg::STATUS_ALLOCATED),
        r_out.result_index == '0, "index set without allocation")

endmodule

// File: src/fba_ram.sv
module fba_ram #(
    parameter int DEPTH = fba_pkg::DEFAULT_NUM_BLOCKS,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: tb/free_list_block_allocator_checker.sv
`timescale 1ns / 100ps

module free_list_block_allocator_checker
    import fba_pkg::*;
#(
    parameter int NUM_BLOCKS = DEFAULT_NUM_BLOCKS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [NUM_BLOCKS-1:0] busy_map;
    int                    link_map [NUM_BLOCKS];
    int                    head_ptr;
    t_out_item             outcome_q [$];
    int                    fail_count = 0;
    int                    result_count = 0;

    function automatic t_out_item pool_request(input t_in_item req);
        t_out_item res;
        int        got;
        res.result_index = '0;
        if (req.mode == MODE_ALLOC) begin
            res.status = STATUS_EMPTY;
            if (head_ptr < NUM_BLOCKS && !busy_map[head_ptr]) begin
                got              = head_ptr;
                busy_map[got]    = 1'b0 | 1'b1;
                head_ptr         = link_map[got];
                res.status       = STATUS_ALLOCATED;
                res.result_index = RES_INDEX_W'(got);
            end
        end else begin
            res.status = STATUS_IGNORED;
            if (int'(req.block_index) < NUM_BLOCKS) begin
                if (busy_map[req.block_index]) begin
                    busy_map[req.block_index] = 1'b0;
                    link_map[req.block_index] = head_ptr;
                    head_ptr                  = int'(req.block_index);
                    res.status                = STATUS_FREED;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            busy_map = '0;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                link_map[i] = i + 1;
            end
            head_ptr = 0;
            outcome_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result %0d arrived with none outstanding: status %0d index %0d",
                                 $time, result_count, i_out_data.status,
                                 i_out_data.result_index);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (i_out_data.status !== want.status ||
                        i_out_data.result_index !== want.result_index) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: result %0d: expected status %0d index %0d, got status %0d index %0d",
                                     $time, result_count, want.status, want.result_index,
                                     i_out_data.status, i_out_data.result_index);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcome_q.push_back(pool_request(i_in_data));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= outcome_q.size();
    end

endmodule

// File: tb/tb_free_list_block_allocator.sv
`timescale 1ns / 100ps

module tb_free_list_block_allocator;
    import fba_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1000;
    localparam int BURST_LEN    = 40;
    localparam int NOISE_PCT    = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;
    int        hold_asked   = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    int        held_q [$];

    always #(HALF_PERIOD) clk = ~clk;

    free_list_block_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    free_list_block_allocator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && !out_stall && out_data.status == STATUS_ALLOCATED) begin
            held_q.push_back(int'(out_data.result_index));
        end
    end

    task automatic offer(input t_in_item req);
        if (req.mode == MODE_FREE) begin
            for (int k = 0; k < held_q.size(); k++) begin
                if (held_q[k] == int'(req.block_index)) begin
                    held_q.delete(k);
                    break;
                end
            end
        end
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    initial begin : stimulus
        t_in_item req;
        bit       counted;
        int       done;
        int       burst_left;
        int       alloc_pct;
        int       roll;
        int       pick;
        done       = 0;
        burst_left = 0;
        alloc_pct  = 50;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer({MODE_FREE, 7'd0});
        offer({MODE_FREE, 7'd127});
        offer({MODE_FREE, 7'd64});
        offer({MODE_ALLOC, 7'd127});
        offer({MODE_ALLOC, 7'd0});
        offer({MODE_ALLOC, 7'd85});
        offer({MODE_FREE, 7'd1});
        offer({MODE_FREE, 7'd1});
        offer({MODE_FREE, 7'd63});
        offer({MODE_ALLOC, 7'd42});
        offer({MODE_FREE, 7'd2});
        offer({MODE_FREE, 7'd0});
        offer({MODE_FREE, 7'd1});
        offer({MODE_ALLOC, 7'd0});
        offer({MODE_ALLOC, 7'd127});
        offer({MODE_ALLOC, 7'd64});
        offer({MODE_ALLOC, 7'd63});

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 7;
                    recv_gap_pct <= 54;
                end
                1: begin
                    send_gap_pct = 54;
                    recv_gap_pct <= 7;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_gap_pct <= 0;
                    hold_asked   <= hold_asked + 1;
                end
            endcase
            while (done < (phase + 1) * RANDOM_ITEMS / 3) begin
                if (burst_left == 0) begin
                    case ($urandom_range(3))
                        0:       alloc_pct = 92;
                        1:       alloc_pct = 70;
                        2:       alloc_pct = 45;
                        default: alloc_pct = 20;
                    endcase
                    burst_left = BURST_LEN;
                end
                roll              = $urandom_range(99);
                req.block_index   = IN_INDEX_W'($urandom_range(127));
                counted           = 1'b1;
                if (roll < NOISE_PCT) begin
                    req.mode = MODE_FREE;
                    counted  = 1'b0;
                end else if (held_q.size() == 0 ||
                             roll < NOISE_PCT + alloc_pct * (100 - NOISE_PCT) / 100) begin
                    req.mode = MODE_ALLOC;
                end else begin
                    pick            = $urandom_range(held_q.size() - 1);
                    req.mode        = MODE_FREE;
                    req.block_index = IN_INDEX_W'(held_q[pick]);
                end
                offer(req);
                if (counted) begin
                    done++;
                    burst_left--;
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Mismatches found");
        $finish;
    end

endmodule
